@@ rtl/core/gpmsd_pkg.sv @@
// Shared types and constants for the Gray-coded PAM mapper and soft demapper.
package gpmsd_pkg;

  // Item kinds on the input channel.
  typedef enum logic {
    KIND_MOD   = 1'b0,
    KIND_DEMOD = 1'b1
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BITS_PER_SYMBOL  = 2'd0;
  localparam logic [1:0] CFG_POWER_NORMALIZER = 2'd1;
  localparam logic [1:0] CFG_NORMAL_MAGNITUDE = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BPS_W     = 4;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned VALUE_W   = 24;

  // Datapath widths, sized for the widest supported symbol (15 bits).
  localparam int unsigned OPND_W  = 18;
  localparam int unsigned PROD_W  = OPND_W + SCALE_W + 1;
  localparam int unsigned DATA_W  = 30;
  localparam int unsigned SHIFT_W = 28;

  // Rounding shifts into Q11.12 and the fraction width of the soft values.
  localparam int unsigned MOD_SHIFT   = 4;
  localparam int unsigned DEMOD_SHIFT = 11;
  localparam int unsigned FRAC_BITS   = 12;

  typedef struct packed {
    kind_t                      kind;
    logic                       data_bit;
    logic                       end_of_block;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } out_item_t;

  // Work handed from the front to the back: a padded symbol or a sample.
  typedef struct packed {
    kind_t                    kind;
    logic signed [OPND_W-1:0] operand;
  } job_t;

endpackage

@@ rtl/core/gpmsd_front.sv @@
// Front end: accepts items, builds Gray-coded symbols and queues work for the back end.
module gpmsd_front
  import gpmsd_pkg::*;
#(
  parameter int unsigned MAX_BITS = 8,
  parameter int unsigned ACC_W    = MAX_BITS + 2,
  parameter int unsigned CNT_W    = $clog2(MAX_BITS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] bps,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    accept;
  logic                    new_neg;
  logic signed [ACC_W-1:0] acc_step;
  logic signed [ACC_W-1:0] fill;
  logic signed [ACC_W-1:0] padded;
  logic signed [OPND_W-1:0] mod_opnd;
  logic signed [OPND_W-1:0] demod_opnd;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        pad;
  logic                    sym_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    new_neg  = neg_r ^ in_item.data_bit;
    acc_step = (acc_r <<< 1) + (new_neg ? -ACC_W'(1) : ACC_W'(1));
    cnt_inc  = cnt_r + 1'b1;
    sym_done = (cnt_inc >= bps) || in_item.end_of_block;
    pad      = (bps > cnt_inc) ? (bps - cnt_inc) : '0;
    // Padding appends pad copies of the running sign, each +1 or -1.
    fill     = (ACC_W'(1) <<< pad) - ACC_W'(1);
    padded   = (acc_step <<< pad) + (new_neg ? -fill : fill);
    mod_opnd   = OPND_W'(padded);
    demod_opnd = OPND_W'(in_item.sample);
  end

  always_comb begin
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    q_push  = 1'b0;
    q_job.kind    = in_item.kind;
    q_job.operand = demod_opnd;
    if (accept && in_item.kind == KIND_MOD) begin
      q_job.operand = mod_opnd;
      if (sym_done) begin
        q_push  = 1'b1;
        acc_nxt = '0;
        neg_nxt = 1'b0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_step;
        neg_nxt = new_neg;
        cnt_nxt = cnt_inc;
      end
    end else if (accept) begin
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      neg_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < MAX_BITS)
    else $error("partial symbol bit count out of range");

endmodule

@@ rtl/core/gpmsd_queue.sv @@
// Short job queue between the front end and the back end.
module gpmsd_queue
  import gpmsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (32'(count_r) == DEPTH);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("queue count exceeds depth");

endmodule

@@ rtl/core/gpmsd_back.sv @@
// Back end: scales each job, then walks the soft values and drives the output register.
module gpmsd_back
  import gpmsd_pkg::*;
#(
  parameter int unsigned CNT_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CNT_W-1:0]   bps,
  input  logic [SCALE_W-1:0] power_normalizer,
  input  logic [SCALE_W-1:0] normal_magnitude,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item
);

  localparam logic signed [DATA_W-1:0] VMAX = DATA_W'(8388607);
  localparam logic signed [DATA_W-1:0] VMIN = -DATA_W'(8388608);

  // Multiply stage.
  logic                     m_valid_r, m_valid_nxt;
  kind_t                    m_kind_r;
  logic signed [PROD_W-1:0] m_prod_r;

  // Soft value stage.
  logic                     e_busy_r, e_busy_nxt;
  logic                     e_demod_r;
  logic signed [DATA_W-1:0] e_a_r;
  logic [SHIFT_W-1:0]       e_sh_r;
  logic [CNT_W-1:0]         e_rem_r;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r;

  logic                     out_free;
  logic                     e_emit;
  logic                     e_done;
  logic                     e_take;
  logic                     m_advance;
  logic signed [SCALE_W:0]  scale;
  logic signed [PROD_W-1:0] product;
  logic signed [PROD_W:0]   sum_mod;
  logic signed [PROD_W:0]   sum_demod;
  logic signed [PROD_W:0]   rnd_mod;
  logic signed [PROD_W:0]   rnd_demod;
  logic signed [DATA_W-1:0] a_load;
  logic signed [DATA_W-1:0] a_abs;
  logic signed [DATA_W-1:0] sh_ext;
  logic signed [DATA_W-1:0] a_next;
  logic [SHIFT_W-1:0]       sh_init;
  logic [VALUE_W-1:0]       sat_value;

  assign out_free  = !out_valid_r || !out_stall;
  assign e_emit    = e_busy_r && out_free;
  assign e_done    = e_emit && (e_rem_r == CNT_W'(1));
  assign e_take    = !e_busy_r || e_done;
  assign m_advance = m_valid_r && e_take;
  assign q_pop     = q_valid && (!m_valid_r || m_advance);

  always_comb begin
    scale   = (q_job.kind == KIND_DEMOD) ? $signed({1'b0, normal_magnitude})
                                         : $signed({1'b0, power_normalizer});
    product = q_job.operand * scale;
  end

  always_comb begin
    sum_mod   = $signed({m_prod_r[PROD_W-1], m_prod_r}) + (PROD_W+1)'(8);
    sum_demod = $signed({m_prod_r[PROD_W-1], m_prod_r}) + (PROD_W+1)'(1024);
    rnd_mod   = sum_mod >>> MOD_SHIFT;
    rnd_demod = sum_demod >>> DEMOD_SHIFT;
    a_load    = (m_kind_r == KIND_DEMOD) ? rnd_demod[DATA_W-1:0] : rnd_mod[DATA_W-1:0];
    sh_init   = SHIFT_W'(1) << (32'(bps) + FRAC_BITS - 1);
    a_abs     = e_a_r[DATA_W-1] ? -e_a_r : e_a_r;
    sh_ext    = $signed({{(DATA_W - SHIFT_W){1'b0}}, e_sh_r});
    a_next    = a_abs - sh_ext;
    if (e_a_r > VMAX) begin
      sat_value = VMAX[VALUE_W-1:0];
    end else if (e_a_r < VMIN) begin
      sat_value = VMIN[VALUE_W-1:0];
    end else begin
      sat_value = e_a_r[VALUE_W-1:0];
    end
  end

  always_comb begin
    m_valid_nxt = m_valid_r;
    if (q_pop) begin
      m_valid_nxt = 1'b1;
    end else if (m_advance) begin
      m_valid_nxt = 1'b0;
    end
    e_busy_nxt = e_busy_r;
    if (m_advance) begin
      e_busy_nxt = 1'b1;
    end else if (e_done) begin
      e_busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (e_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      e_busy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_valid_r   <= m_valid_nxt;
      e_busy_r    <= e_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_kind_r <= q_job.kind;
      m_prod_r <= product;
    end
    if (m_advance) begin
      e_demod_r <= (m_kind_r == KIND_DEMOD);
      e_a_r     <= a_load;
      e_sh_r    <= sh_init;
      e_rem_r   <= (m_kind_r == KIND_DEMOD) ? bps : CNT_W'(1);
    end else if (e_emit) begin
      e_a_r   <= a_next;
      e_sh_r  <= e_sh_r >> 1;
      e_rem_r <= e_rem_r - 1'b1;
    end
    if (e_emit) begin
      out_item_r.value <= sat_value;
      out_item_r.last  <= e_demod_r && (e_rem_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    e_busy_r |-> (e_rem_r != '0))
    else $error("soft value stage busy with nothing left to emit");

  a_mult_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && !e_take) |=> (m_valid_r && $stable(m_prod_r)))
    else $error("product lost while the soft value stage was busy");

endmodule

@@ rtl/core/gray_pam_mapper_soft_demapper.sv @@
// Top level of the Gray-coded PAM mapper with max-log soft demapper.
// Path: an item that completes a symbol passes through the queue, the multiply stage and
// the soft value stage into the output register, and waits longer if stalled.
// Throughput: one modulate item per cycle unless the queue is full; the soft value stage
// emits one soft value per cycle while the output is not stalled, bits_per_symbol per sample.
// Reset: synchronous, active low; clears the partial symbol, the queue and all valid flags,
// and loads bits_per_symbol 1, power_normalizer 65535 and normal_magnitude 1024.
module gray_pam_mapper_soft_demapper
  import gpmsd_pkg::*;
#(
  parameter int unsigned MAX_BITS_PER_SYMBOL = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  // The accumulator holds up to MAX_BITS_PER_SYMBOL signed bits plus headroom.
  localparam int unsigned ACC_W = MAX_BITS_PER_SYMBOL + 2;
  localparam int unsigned CNT_W = $clog2(MAX_BITS_PER_SYMBOL + 1);
  localparam int unsigned QUEUE_DEPTH = 4;

  logic [BPS_W-1:0]   bps_r, bps_nxt;
  logic [SCALE_W-1:0] pn_r, pn_nxt;
  logic [SCALE_W-1:0] nm_r, nm_nxt;
  logic [CNT_W-1:0]   bps_eff;

  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  // Configuration is always taken; the register file sits at the top so that both
  // halves see the same values.
  assign cfg_ready = 1'b1;

  always_comb begin
    bps_nxt = bps_r;
    pn_nxt  = pn_r;
    nm_nxt  = nm_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BITS_PER_SYMBOL:  bps_nxt = cfg_data[BPS_W-1:0];
        CFG_POWER_NORMALIZER: pn_nxt  = cfg_data;
        CFG_NORMAL_MAGNITUDE: nm_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= BPS_W'(1);
      pn_r  <= SCALE_W'(65535);
      nm_r  <= SCALE_W'(1024);
    end else begin
      bps_r <= bps_nxt;
      pn_r  <= pn_nxt;
      nm_r  <= nm_nxt;
    end
  end

  // Zero bits per symbol behaves as one; values above the supported maximum clamp to it.
  always_comb begin
    if (bps_r == '0) begin
      bps_eff = CNT_W'(1);
    end else if (32'(bps_r) > MAX_BITS_PER_SYMBOL) begin
      bps_eff = CNT_W'(MAX_BITS_PER_SYMBOL);
    end else begin
      bps_eff = CNT_W'(bps_r);
    end
  end

  // The front end builds symbols bit by bit and forwards samples untouched. It only
  // stalls the input when the queue is full, so modulate bits keep flowing while the
  // back end is still walking the soft values of an earlier sample.
  gpmsd_front #(
    .MAX_BITS (MAX_BITS_PER_SYMBOL),
    .ACC_W    (ACC_W),
    .CNT_W    (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .bps      (bps_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  gpmsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  // The back end shares one multiplier between symbol scaling and sample scaling,
  // rounds into Q11.12 and emits one saturated value per cycle through its output
  // register while the output is not stalled; a value waiting downstream holds the soft value stage.
  gpmsd_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .bps              (bps_eff),
    .power_normalizer (pn_r),
    .normal_magnitude (nm_r),
    .q_valid          (q_valid),
    .q_job            (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item)
  );

endmodule

@@ bench/gray_pam_mapper_soft_demapper_tb.sv @@
// Self-checking testbench for the Gray-coded PAM mapper and max-log soft demapper.
module gray_pam_mapper_soft_demapper_tb;
  import gpmsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built for eight bits per symbol; larger register values clamp to it.
  localparam int unsigned MAX_BPS = 8;
  // The register port has room for one more index than there are registers.
  // Writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam longint VALUE_HI = 64'sd8388607;
  localparam longint VALUE_LO = -64'sd8388608;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 50;
  // This is how long the result side holds off when a long back-pressure stretch is requested.
  localparam int unsigned HOLD_CYCLES = 300;
  // Extra cycles after the last result, so that the block is idle before a register is touched.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0] cfg_data = '0;

  gray_pam_mapper_soft_demapper #(
    .MAX_BITS_PER_SYMBOL(MAX_BPS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock period is 8 ns.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // This is our own copy of the register file. It follows every completed write.
  logic [BPS_W-1:0] bps_shadow = 4'd1;
  logic [SCALE_W-1:0] pnorm_shadow = 16'hFFFF;
  logic [SCALE_W-1:0] nmag_shadow = 16'd1024;

  // Modulator state: the doubling sum of signs, the running Gray sign and
  // the number of bits folded into the current symbol.
  longint symbol_sum = 0;
  longint run_sign = 1;
  int unsigned bits_held = 0;

  // Items waiting to be offered, and the values the block owes us, oldest first.
  in_item_t pending_items[$];
  out_item_t owed_values[$];
  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;

  // Each phase can turn idling on or off per side. A request for a long hold is
  // counted here and served by the result side in its own process.
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned draw_gap(bit enabled);
    if (!enabled) return 0;
    return $urandom_range(0, 16);
  endfunction

  // A zero register means one bit per symbol. Anything above the build limit
  // means the limit.
  function automatic int unsigned symbol_bits();
    if (bps_shadow == 0) return 1;
    if (bps_shadow > MAX_BPS) return MAX_BPS;
    return 32'(bps_shadow);
  endfunction

  // This is the same as floor((x + 2^(n-1)) / 2^n). An arithmetic shift floors.
  function automatic longint round_up_shift(longint x, int unsigned n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clip_value(longint v);
    if (v > VALUE_HI) return VALUE_HI[VALUE_W-1:0];
    if (v < VALUE_LO) return VALUE_LO[VALUE_W-1:0];
    return v[VALUE_W-1:0];
  endfunction

  // This works out what one accepted item owes and updates the modulator state.
  task automatic predict_modem(input in_item_t it);
    int unsigned n;
    int unsigned k;
    longint amp;
    longint step;
    out_item_t r;
    n = symbol_bits();
    if (it.kind == KIND_MOD) begin
      if (it.data_bit) run_sign = -run_sign;
      symbol_sum = 2 * symbol_sum + run_sign;
      bits_held++;
      // A symbol is done when it holds enough bits or the block ends here.
      // A short symbol is padded with the current sign.
      if (bits_held >= n || it.end_of_block) begin
        while (bits_held < n) begin
          symbol_sum = 2 * symbol_sum + run_sign;
          bits_held++;
        end
        r.value = clip_value(round_up_shift(symbol_sum * longint'(pnorm_shadow), MOD_SHIFT));
        r.last = 1'b0;
        owed_values = {owed_values, r};
        symbol_sum = 0;
        run_sign = 1;
        bits_held = 0;
      end
    end else begin
      // The first soft value is the scaled amplitude. Each later one folds the
      // previous value around a threshold that halves at every step.
      amp = round_up_shift(longint'(it.sample) * longint'(nmag_shadow), DEMOD_SHIFT);
      step = longint'(1) <<< (n - 1 + FRAC_BITS);
      for (k = 0; k < n; k++) begin
        r.value = clip_value(amp);
        r.last = (k == n - 1);
        owed_values = {owed_values, r};
        amp = ((amp < 0) ? -amp : amp) - step;
        step = step >>> 1;
      end
    end
  endtask

  // The driver offers queued items after a drawn gap. It works out the expected
  // values at the edge where an item is accepted. At that edge the register
  // copy matches the block, because registers change only while it is idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_modem(in_item);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_wait = draw_gap(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor checks each accepted result against the oldest expectation,
  // one field at a time. It then decides its stall for the next cycle: a
  // requested long hold wins, and otherwise it waits a drawn number of cycles
  // after each result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_values.size() == 0) begin
          $display("%0t: unexpected result, value %0d last %0b",
                   $time, out_item.value, out_item.last);
          fail_count++;
        end else begin
          if (out_item.value !== owed_values[0].value) begin
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, owed_values[0].value, out_item.value);
            fail_count++;
          end
          if (out_item.last !== owed_values[0].last) begin
            $display("%0t: last mismatch, expected %0b actual %0b",
                     $time, owed_values[0].last, out_item.last);
            fail_count++;
          end
          void'(owed_values.pop_front());
        end
        recv_wait = draw_gap(recv_idle_on);
      end
      if (hold_left == 0 && holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d values still owed", $time, owed_values.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input in_item_t it);
    pending_items = {pending_items, it};
    items_pushed++;
  endtask

  task automatic push_mod(input logic data_bit, input logic end_of_block);
    in_item_t it;
    it = '0;
    it.kind = KIND_MOD;
    it.data_bit = data_bit;
    it.end_of_block = end_of_block;
    push_item(it);
  endtask

  task automatic push_demod(input logic signed [SAMPLE_W-1:0] sample);
    in_item_t it;
    it = '0;
    it.kind = KIND_DEMOD;
    it.sample = sample;
    push_item(it);
  endtask

  // This waits until every queued item has been accepted and every owed value
  // has arrived. It then lets the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (items_taken != items_pushed || owed_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // This writes one register and updates our copy once the write handshake
  // completes. Starting on a fresh edge keeps the drive to one assignment per
  // time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BITS_PER_SYMBOL: bps_shadow = data[BPS_W-1:0];
      CFG_POWER_NORMALIZER: pnorm_shadow = data;
      CFG_NORMAL_MAGNITUDE: nmag_shadow = data;
      default: ;
    endcase
  endtask

  // Stimulus comes first as a directed part with the reset settings and a few
  // chosen ones. Random phases follow. Each phase starts from an idle block
  // with new register values.
  initial begin
    in_item_t it;
    int unsigned p;
    int unsigned i;
    logic [BPS_W-1:0] phase_bps[RANDOM_PHASES];
    logic [SCALE_W-1:0] pn;
    logic [SCALE_W-1:0] nm;

    phase_bps = '{4'd8, 4'd15, 4'd2, 4'd4, 4'd0, 4'd9, 4'd5, 4'd7, 4'd6, 4'd3};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // With reset settings, each bit is a symbol and each sample yields one soft value.
    push_mod(1'b0, 1'b0);
    push_mod(1'b1, 1'b0);
    push_demod(16'sh7FFF);
    push_demod(16'sh8000);
    wait_drained();

    write_reg(CFG_BITS_PER_SYMBOL, 16'd3);
    write_reg(CFG_NORMAL_MAGNITUDE, 16'hFFFF);
    // This sends a full three-bit symbol, then a lone bit that ends a block
    // and gets padded.
    push_mod(1'b1, 1'b0);
    push_mod(1'b0, 1'b0);
    push_mod(1'b1, 1'b0);
    push_mod(1'b1, 1'b1);
    // Here the block ends on a full symbol, so no padding is added.
    push_mod(1'b0, 1'b0);
    push_mod(1'b1, 1'b0);
    push_mod(1'b1, 1'b1);
    push_demod(16'sh7FFF);
    push_demod(16'sh8000);
    push_demod(16'sh0000);
    push_demod(16'shFFFF);
    // A sample arrives in the middle of a symbol, and the partial symbol must
    // survive it. Two bits are left pending across the register change below.
    push_mod(1'b0, 1'b0);
    push_demod(16'sh0001);
    push_mod(1'b1, 1'b0);
    wait_drained();

    // Zero bits per symbol acts as one. Two bits are already held, so the next
    // bit completes the symbol at once. The upper data bits must be masked away.
    write_reg(CFG_BITS_PER_SYMBOL, 16'hFFF0);
    write_reg(CFG_POWER_NORMALIZER, 16'h0000);
    write_reg(CFG_UNUSED_INDEX, 16'h1234);
    push_mod(1'b0, 1'b0);
    push_demod(16'sh5555);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      pn = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
      nm = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0400 :
           16'($urandom_range(0, 65535));
      // Random upper bits check that the register width masks the data.
      write_reg(CFG_BITS_PER_SYMBOL, {12'($urandom()), phase_bps[p]});
      write_reg(CFG_POWER_NORMALIZER, pn);
      write_reg(CFG_NORMAL_MAGNITUDE, nm);
      if (p == 5) write_reg(CFG_UNUSED_INDEX, 16'($urandom()));

      // Each phase cycles through no idling, sender idling, receiver idling, and both.
      send_idle_on = (p % 4 == 1) || (p % 4 == 3);
      recv_idle_on = (p % 4 == 2) || (p % 4 == 3);
      // In two phases the result side holds off for a long stretch while the
      // sender keeps offering items without a gap, so the block fills up and
      // stalls its input.
      if (p == 2 || p == 7) begin
        send_idle_on = 1'b0;
        hold_requests++;
      end

      for (i = 0; i < PHASE_ITEMS; i++) begin
        it.kind = ($urandom_range(0, 9) < 6) ? KIND_MOD : KIND_DEMOD;
        it.data_bit = 1'($urandom_range(0, 1));
        it.end_of_block = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 15))
          0: it.sample = 16'sh7FFF;
          1: it.sample = 16'sh8000;
          2: it.sample = 16'sh0000;
          3: it.sample = 16'shFFFF;
          default: it.sample = 16'($urandom());
        endcase
        push_item(it);
      end
      // The sender pauses here until every owed value has come back.
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
